### hdl/tct_pkg.sv
// Shared types and codes for the trusted code table.
package tct_pkg;

  localparam logic [1:0] REQ_CHECK  = 2'd0;
  localparam logic [1:0] REQ_ADD    = 2'd1;
  localparam logic [1:0] REQ_REMOVE = 2'd2;

  localparam logic [2:0] ST_DONE     = 3'd0;
  localparam logic [2:0] ST_IGNORED  = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_PRESENT  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FINISH
  } fsm_state_t;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] code_value;
  } in_word_t;

  typedef struct packed {
    logic       gate_trigger;
    logic [2:0] status;
    logic [3:0] entry_count;
  } out_word_t;

  typedef struct packed {
    logic valid;
    logic hit;
  } tct_tok_t;

  typedef struct packed {
    logic add_en;
    logic rem_en;
  } cell_ctrl_t;

endpackage

### hdl/tct_cell.sv
// One entry of the table: stored code, compare, and search token stage.
module tct_cell import tct_pkg::*; #(
  parameter int IDX = 0,
  parameter int CW  = 4
) (
  input  logic          clk,
  input  logic          rst,
  input  tct_tok_t      tok_in,
  output tct_tok_t      tok_out,
  input  logic [31:0]   code,
  input  logic [CW-1:0] count,
  input  cell_ctrl_t    ctrl,
  input  logic [31:0]   next_entry,
  output logic [31:0]   entry
);

  logic match;
  logic shift_flag;

  assign match = (CW'(IDX) < count) && (entry == code);

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else begin
      tok_out.valid <= tok_in.valid;
    end
    tok_out.hit <= tok_in.hit || match;
    if (tok_in.valid) begin
      shift_flag <= tok_in.hit || match;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.add_en && (count == CW'(IDX))) begin
      entry <= code;
    end else if (ctrl.rem_en && shift_flag) begin
      entry <= next_entry;
    end
  end

endmodule

### hdl/trusted_code_table.sv
// Top level of the trusted code table: control sequencer and row of entry cells.
//
// Input channel in_valid/in_stall carries one request word: req_type (check,
// add, remove) and a 32-bit code_value. Output channel out_valid/out_stall
// returns one result word per request: gate_trigger, status, entry_count.
// A word moves at a rising edge with valid high and stall low.
//
// Each request runs a search token down the row of MAX_ENTRIES cells, one
// cell per cycle, then commits. One request is in work at a time, so a new
// request is taken only once the previous one has committed its result.
// A remove closes the gap by moving every later entry one cell down in the
// commit cycle.
//
// Reset empties the table (count zero) and drops any pending result. When
// the receiver stalls, the result word holds; the next request may be
// accepted and searched meanwhile, but its commit waits for the output
// register to free up.
module trusted_code_table import tct_pkg::*; #(
  parameter int MAX_ENTRIES = 10
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_word_t  in_word,
  output logic      out_valid,
  input  logic      out_stall,
  output out_word_t out_word
);

  localparam int CW = $clog2(MAX_ENTRIES + 1);

  fsm_state_t    state, state_next;
  logic          start;
  logic [1:0]    req_type;
  logic [31:0]   code;
  logic          found;
  logic [CW-1:0] count, count_next;
  logic          out_free;
  logic          commit;
  logic          accept;
  cell_ctrl_t    ctrl;
  logic          trig;
  logic [2:0]    status;
  logic [CW+3:0] count_ext;

  tct_tok_t      tok [MAX_ENTRIES+1];
  logic [31:0]   ent [MAX_ENTRIES];

  assign tok[0].valid = start;
  assign tok[0].hit   = 1'b0;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic [31:0] nxt;
    if (i == MAX_ENTRIES - 1) begin : g_last
      assign nxt = code;
    end else begin : g_mid
      assign nxt = ent[i+1];
    end
    tct_cell #(.IDX(i), .CW(CW)) u_cell (
      .clk        (clk),
      .rst        (rst),
      .tok_in     (tok[i]),
      .tok_out    (tok[i+1]),
      .code       (code),
      .count      (count),
      .ctrl       (ctrl),
      .next_entry (nxt),
      .entry      (ent[i])
    );
  end

  assign in_stall = (state != FSM_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next = state;
    count_next = count;
    commit     = 1'b0;
    ctrl       = '0;
    trig       = 1'b0;
    status     = ST_DONE;
    case (state)
      FSM_IDLE: begin
        if (accept) begin
          state_next = FSM_SCAN;
        end
      end
      FSM_SCAN: begin
        if (tok[MAX_ENTRIES].valid) begin
          state_next = FSM_FINISH;
        end
      end
      FSM_FINISH: begin
        commit = out_free;
        case (req_type)
          REQ_CHECK: begin
            if (code == 32'd0) begin
              status = ST_IGNORED;
            end else if (found) begin
              trig = 1'b1;
            end else begin
              status = ST_NOTFOUND;
            end
          end
          REQ_ADD: begin
            if (found) begin
              status = ST_PRESENT;
            end else if (count == CW'(MAX_ENTRIES)) begin
              status = ST_FULL;
            end else begin
              ctrl.add_en = commit;
              count_next  = count + 1'b1;
            end
          end
          REQ_REMOVE: begin
            if (!found) begin
              status = ST_NOTFOUND;
            end else begin
              ctrl.rem_en = commit;
              count_next  = count - 1'b1;
            end
          end
          default: begin
            status = ST_IGNORED;
          end
        endcase
        if (commit) begin
          state_next = FSM_IDLE;
        end else begin
          count_next = count;
        end
      end
      default: begin
        state_next = FSM_IDLE;
      end
    endcase
  end

  assign count_ext = {4'd0, count_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= FSM_IDLE;
      start     <= 1'b0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      start <= accept;
      count <= count_next;
      if (commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
    if (accept) begin
      req_type <= in_word.req_type;
      code     <= in_word.code_value;
    end
    if (tok[MAX_ENTRIES].valid) begin
      found <= tok[MAX_ENTRIES].hit;
    end
    if (commit) begin
      out_word.gate_trigger <= trig;
      out_word.status       <= status;
      out_word.entry_count  <= count_ext[3:0];
    end
  end

endmodule

### hdl/tct_checker.sv
// Port-level checks for the trusted code table, bound to the top level.
module tct_checker import tct_pkg::*; (
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input in_word_t  in_word,
  input logic      out_valid,
  input logic      out_stall,
  input out_word_t out_word
);

  a_in_hold: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_stall |=> in_valid && $stable(in_word))
    else $error("request word changed while stalled");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(out_word))
    else $error("result word changed while stalled");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one still in work");

  a_trig_done: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_word.gate_trigger |-> out_word.status == ST_DONE)
    else $error("gate trigger with non-done status");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (out_word.status == ST_DONE || out_word.status == ST_IGNORED ||
                   out_word.status == ST_NOTFOUND || out_word.status == ST_PRESENT ||
                   out_word.status == ST_FULL))
    else $error("status code out of range");

endmodule

bind trusted_code_table tct_checker u_tct_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_word   (in_word),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_word  (out_word)
);

### sim/testbench.sv
// Self-checking testbench for the trusted code table: directed table, then random requests.
module testbench import tct_pkg::*;;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int TABLE_DEPTH = 10;
  localparam int DIRECTED = 25;
  localparam int RANDOM_ITEMS = 750;
  localparam logic [1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    in_word_t  req;
    logic      typed;
    out_word_t want;
  } plan_row_t;

  localparam plan_row_t PLAN [DIRECTED] = '{
    '{'{REQ_CHECK,  32'h0000_0000}, 1'b1, '{1'b0, ST_IGNORED,  4'd0}},
    '{'{REQ_CHECK,  32'h1234_5678}, 1'b1, '{1'b0, ST_NOTFOUND, 4'd0}},
    '{'{REQ_REMOVE, 32'hDEAD_BEEF}, 1'b1, '{1'b0, ST_NOTFOUND, 4'd0}},
    '{'{REQ_UNUSED, 32'hFFFF_FFFF}, 1'b1, '{1'b0, ST_IGNORED,  4'd0}},
    '{'{REQ_ADD,    32'h0000_0000}, 1'b1, '{1'b0, ST_DONE,     4'd1}},
    '{'{REQ_CHECK,  32'h0000_0000}, 1'b1, '{1'b0, ST_IGNORED,  4'd1}},
    '{'{REQ_ADD,    32'hFFFF_FFFF}, 1'b1, '{1'b0, ST_DONE,     4'd2}},
    '{'{REQ_ADD,    32'hFFFF_FFFF}, 1'b1, '{1'b0, ST_PRESENT,  4'd2}},
    '{'{REQ_CHECK,  32'hFFFF_FFFF}, 1'b1, '{1'b1, ST_DONE,     4'd2}},
    '{'{REQ_ADD,    32'h8000_0000}, 1'b1, '{1'b0, ST_DONE,     4'd3}},
    '{'{REQ_ADD,    32'h0000_0001}, 1'b0, '0},
    '{'{REQ_ADD,    32'hAAAA_AAAA}, 1'b0, '0},
    '{'{REQ_ADD,    32'h5555_5555}, 1'b0, '0},
    '{'{REQ_ADD,    32'h7FFF_FFFF}, 1'b0, '0},
    '{'{REQ_ADD,    32'hFFFF_FFFE}, 1'b0, '0},
    '{'{REQ_ADD,    32'h0001_0000}, 1'b0, '0},
    '{'{REQ_ADD,    32'h0000_FFFF}, 1'b1, '{1'b0, ST_DONE,     4'd10}},
    '{'{REQ_ADD,    32'hC0FF_EE00}, 1'b1, '{1'b0, ST_FULL,     4'd10}},
    '{'{REQ_ADD,    32'h5555_5555}, 1'b1, '{1'b0, ST_PRESENT,  4'd10}},
    '{'{REQ_REMOVE, 32'h8000_0000}, 1'b1, '{1'b0, ST_DONE,     4'd9}},
    '{'{REQ_CHECK,  32'h8000_0000}, 1'b1, '{1'b0, ST_NOTFOUND, 4'd9}},
    '{'{REQ_CHECK,  32'h0000_FFFF}, 1'b1, '{1'b1, ST_DONE,     4'd9}},
    '{'{REQ_REMOVE, 32'h0000_0000}, 1'b1, '{1'b0, ST_DONE,     4'd8}},
    '{'{REQ_REMOVE, 32'h0000_FFFF}, 1'b1, '{1'b0, ST_DONE,     4'd7}},
    '{'{REQ_UNUSED, 32'h0000_0000}, 1'b1, '{1'b0, ST_IGNORED,  4'd7}}
  };

  logic      clk;
  logic      rst;
  logic      in_valid;
  logic      in_stall;
  in_word_t  in_word;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  logic [31:0] trusted_codes [TABLE_DEPTH];
  int          trusted_count;
  out_word_t   pending_results [$];
  int          mismatches = 0;
  bit          quiet;

  trusted_code_table #(.MAX_ENTRIES(TABLE_DEPTH)) dut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_word(in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word(out_word)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

  function automatic int find_trusted(input logic [31:0] code);
    int pos;
    pos = -1;
    for (int i = trusted_count - 1; i >= 0; i--) begin
      if (trusted_codes[i] == code) pos = i;
    end
    return pos;
  endfunction

  function automatic out_word_t apply_request(input in_word_t w);
    out_word_t res;
    int pos;
    res = '0;
    res.status = ST_DONE;
    pos = find_trusted(w.code_value);
    case (w.req_type)
      REQ_CHECK: begin
        if (w.code_value == 32'd0) res.status = ST_IGNORED;
        else if (pos >= 0) res.gate_trigger = 1'b1;
        else res.status = ST_NOTFOUND;
      end
      REQ_ADD: begin
        if (pos >= 0) res.status = ST_PRESENT;
        else if (trusted_count >= TABLE_DEPTH) res.status = ST_FULL;
        else begin
          trusted_codes[trusted_count] = w.code_value;
          trusted_count++;
        end
      end
      REQ_REMOVE: begin
        if (pos < 0) res.status = ST_NOTFOUND;
        else begin
          for (int i = pos; i < trusted_count - 1; i++) trusted_codes[i] = trusted_codes[i + 1];
          trusted_count--;
        end
      end
      default: res.status = ST_IGNORED;
    endcase
    res.entry_count = trusted_count[3:0];
    return res;
  endfunction

  // Lean toward adds when nearly empty and removes when nearly full; reuse held codes often.
  function automatic in_word_t random_request();
    in_word_t w;
    int roll;
    int add_pct;
    int rem_pct;
    add_pct = (trusted_count <= 2) ? 50 : ((trusted_count >= TABLE_DEPTH - 1) ? 20 : 33);
    rem_pct = (trusted_count >= TABLE_DEPTH - 1) ? 40 : 25;
    roll = $urandom_range(0, 99);
    if (roll < 4) w.req_type = REQ_UNUSED;
    else if (roll < 4 + add_pct) w.req_type = REQ_ADD;
    else if (roll < 4 + add_pct + rem_pct) w.req_type = REQ_REMOVE;
    else w.req_type = REQ_CHECK;
    roll = $urandom_range(0, 99);
    if (trusted_count > 0 && roll < 55)
      w.code_value = trusted_codes[$urandom_range(0, trusted_count - 1)];
    else if (roll < 63) w.code_value = 32'd0;
    else if (roll < 78) w.code_value = $urandom_range(1, 12);
    else w.code_value = $urandom;
    return w;
  endfunction

  task automatic send_request(input in_word_t w, input logic typed, input out_word_t want);
    out_word_t predicted;
    @(negedge clk);
    while (!quiet && $urandom_range(0, 99) < 23) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    predicted = apply_request(w);
    pending_results.push_back(typed ? want : predicted);
  endtask

  task automatic flag_error(input out_word_t want, input logic none_waiting);
    if (mismatches < 10) begin
      if (none_waiting)
        $display("unexpected result word: trig=%0d status=%0d count=%0d",
                 out_word.gate_trigger, out_word.status, out_word.entry_count);
      else
        $display("mismatch: want trig=%0d st=%0d cnt=%0d, got trig=%0d st=%0d cnt=%0d",
                 want.gate_trigger, want.status, want.entry_count,
                 out_word.gate_trigger, out_word.status, out_word.entry_count);
    end
    mismatches++;
  endtask

  always @(negedge clk) begin
    out_stall <= !quiet && ($urandom_range(0, 99) < 23);
  end

  always @(posedge clk) begin
    out_word_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        flag_error('0, 1'b1);
      end else begin
        want = pending_results.pop_front();
        if (out_word.gate_trigger !== want.gate_trigger || out_word.status !== want.status ||
            out_word.entry_count !== want.entry_count)
          flag_error(want, 1'b0);
      end
    end
  end

  initial begin
    in_word_t w;
    quiet = 1'b0;
    trusted_count = 0;
    in_valid = 1'b0;
    in_word = '0;
    rst = 1'b1;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    for (int k = 0; k < DIRECTED; k++) send_request(PLAN[k].req, PLAN[k].typed, PLAN[k].want);
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      quiet = (k >= 300 && k < 450);
      w = random_request();
      send_request(w, 1'b0, '0);
    end
    quiet = 1'b0;
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (3 * TABLE_DEPTH) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

endmodule

### trusted_code_table.f
hdl/tct_pkg.sv
hdl/tct_cell.sv
hdl/trusted_code_table.sv
hdl/tct_checker.sv
sim/testbench.sv
